// ----- rtl/surd_pkg.sv -----
`default_nettype none

package surd_pkg;

  typedef enum logic [1:0] {
    OP_MUL_SIMP = 2'd0,
    OP_MUL_RAW  = 2'd1,
    OP_ADD      = 2'd2,
    OP_SUB      = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_NEG_B,
    DP_MUL_N,
    DP_MUL_D,
    DP_MUL_R,
    DP_JINIT,
    DP_JSQ,
    DP_DIV_R,
    DP_R_UPD,
    DP_MUL_NJ,
    DP_JINC,
    DP_GCD_N,
    DP_GCD_A,
    DP_DIV_XY,
    DP_GCD_STEP,
    DP_DIV_M,
    DP_N_UPD,
    DP_DIV_D,
    DP_D_UPD,
    DP_B_SAVE,
    DP_DIV_AD,
    DP_Q1,
    DP_DIV_BD,
    DP_Q2,
    DP_MUL_L,
    DP_MUL_T1,
    DP_MUL_T2,
    DP_SUM,
    DP_OUT
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic r_ge4;
    logic jj_gt_r;
    logic rem_zero;
    logic y_zero;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/surd_div.sv -----
`default_nettype none

module surd_div #(
  parameter int W = 47
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fit;

  assign shifted   = {rem_r, quo_r[W-1]};
  assign diff      = shifted - {1'b0, dvs_r};
  assign fit       = shifted >= {1'b0, dvs_r};
  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fit ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fit};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a run");

endmodule

`default_nettype wire

// ----- rtl/surd_dp.sv -----
`default_nettype none

module surd_dp import surd_pkg::*; #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dp_cmd_t                             cmd,
  output dp_status_t                          status,
  input  logic [1:0]                          in_operation,
  input  logic signed [OPERAND_BITS-1:0]      in_a_num,
  input  logic [OPERAND_BITS-2:0]             in_a_den,
  input  logic [OPERAND_BITS-2:0]             in_a_root,
  input  logic signed [OPERAND_BITS-1:0]      in_b_num,
  input  logic [OPERAND_BITS-2:0]             in_b_den,
  input  logic [OPERAND_BITS-2:0]             in_b_root,
  output logic signed [3*OPERAND_BITS-2:0]    out_res_num,
  output logic [2*OPERAND_BITS-3:0]           out_res_den,
  output logic [2*OPERAND_BITS-3:0]           out_res_root
);

  localparam int P  = OPERAND_BITS;
  localparam int DW = P - 1;
  localparam int WW = 2 * DW;
  localparam int NW = 3 * P - 1;
  localparam int MW = P + 1;
  localparam int PW = NW + MW;

  op_t           op_r;
  logic [P-1:0]  an_r;
  logic [DW-1:0] ad_r;
  logic [DW-1:0] ar_r;
  logic [NW-1:0] bn_r;
  logic [DW-1:0] bd_r;
  logic [DW-1:0] br_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] t_r;
  logic [WW-1:0] d_r;
  logic [WW-1:0] r_r;
  logic [P-1:0]  j_r;
  logic [WW:0]   jj_r;
  logic [NW-1:0] x_r;
  logic [NW-1:0] y_r;
  logic [DW-1:0] q1_r;
  logic [DW-1:0] q2_r;
  logic [NW-1:0] res_num_r;
  logic [WW-1:0] res_den_r;
  logic [WW-1:0] res_root_r;

  logic [NW-1:0]        mul_a;
  logic [MW-1:0]        mul_b;
  logic signed [PW-1:0] prod;
  logic [NW-1:0]        prod_lo;
  logic [NW-1:0]        n_mag;
  logic [NW-1:0]        an_ext;
  logic                 div_start;
  logic [NW-1:0]        div_a;
  logic [NW-1:0]        div_b;
  logic [NW-1:0]        quo;
  logic [NW-1:0]        rem;
  logic                 div_done;

  assign an_ext  = {{(NW-P){an_r[P-1]}}, an_r};
  assign n_mag   = n_r[NW-1] ? (NW'(0) - n_r) : n_r;
  assign prod    = $signed(mul_a) * $signed(mul_b);
  assign prod_lo = prod[NW-1:0];

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (cmd)
      DP_MUL_N: begin
        mul_a = an_ext;
        mul_b = {bn_r[P-1], bn_r[P-1:0]};
      end
      DP_MUL_D: begin
        mul_a = {{(NW-DW){1'b0}}, ad_r};
        mul_b = {2'b00, bd_r};
      end
      DP_MUL_R: begin
        mul_a = {{(NW-DW){1'b0}}, ar_r};
        mul_b = {2'b00, br_r};
      end
      DP_JSQ: begin
        mul_a = {{(NW-P){1'b0}}, j_r};
        mul_b = {1'b0, j_r};
      end
      DP_MUL_NJ: begin
        mul_a = n_r;
        mul_b = {1'b0, j_r};
      end
      DP_MUL_L: begin
        mul_a = {{(NW-DW){1'b0}}, q1_r};
        mul_b = {2'b00, bd_r};
      end
      DP_MUL_T1: begin
        mul_a = an_ext;
        mul_b = {2'b00, q2_r};
      end
      DP_MUL_T2: begin
        mul_a = bn_r;
        mul_b = {2'b00, q1_r};
      end
      DP_DIV_R: begin
        div_start = 1'b1;
        div_a     = {{(NW-WW){1'b0}}, r_r};
        div_b     = {{(NW-WW-1){1'b0}}, jj_r};
      end
      DP_DIV_XY: begin
        div_start = 1'b1;
        div_a     = x_r;
        div_b     = y_r;
      end
      DP_DIV_M: begin
        div_start = 1'b1;
        div_a     = n_mag;
        div_b     = x_r;
      end
      DP_DIV_D: begin
        div_start = 1'b1;
        div_a     = {{(NW-WW){1'b0}}, d_r};
        div_b     = x_r;
      end
      DP_DIV_AD: begin
        div_start = 1'b1;
        div_a     = {{(NW-DW){1'b0}}, ad_r};
        div_b     = x_r;
      end
      DP_DIV_BD: begin
        div_start = 1'b1;
        div_a     = {{(NW-DW){1'b0}}, bd_r};
        div_b     = x_r;
      end
      default: begin
      end
    endcase
  end

  surd_div #(.W(NW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    case (cmd)
      DP_LOAD: begin
        op_r <= op_t'(in_operation);
        an_r <= in_a_num;
        ad_r <= (in_a_den == '0) ? DW'(1) : in_a_den;
        ar_r <= in_a_root;
        bn_r <= {{(NW-P){in_b_num[P-1]}}, in_b_num};
        bd_r <= (in_b_den == '0) ? DW'(1) : in_b_den;
        br_r <= in_b_root;
      end
      DP_NEG_B: begin
        n_r <= NW'(0) - bn_r;
        d_r <= {{(WW-DW){1'b0}}, bd_r};
        r_r <= {{(WW-DW){1'b0}}, br_r};
      end
      DP_MUL_N:    n_r  <= prod_lo;
      DP_MUL_D:    d_r  <= prod_lo[WW-1:0];
      DP_MUL_R:    r_r  <= prod_lo[WW-1:0];
      DP_JINIT:    j_r  <= P'(2);
      DP_JSQ:      jj_r <= prod_lo[WW:0];
      DP_R_UPD:    r_r  <= quo[WW-1:0];
      DP_MUL_NJ:   n_r  <= prod_lo;
      DP_JINC:     j_r  <= j_r + 1'b1;
      DP_GCD_N: begin
        x_r <= n_mag;
        y_r <= {{(NW-WW){1'b0}}, d_r};
      end
      DP_GCD_A: begin
        x_r <= {{(NW-DW){1'b0}}, ad_r};
        y_r <= {{(NW-DW){1'b0}}, bd_r};
      end
      DP_GCD_STEP: begin
        x_r <= y_r;
        y_r <= rem;
      end
      DP_N_UPD:    n_r  <= n_r[NW-1] ? (NW'(0) - quo) : quo;
      DP_D_UPD:    d_r  <= quo[WW-1:0];
      DP_B_SAVE: begin
        bn_r <= n_r;
        bd_r <= d_r[DW-1:0];
      end
      DP_Q1:       q1_r <= quo[DW-1:0];
      DP_Q2:       q2_r <= quo[DW-1:0];
      DP_MUL_L:    d_r  <= prod_lo[WW-1:0];
      DP_MUL_T1:   n_r  <= prod_lo;
      DP_MUL_T2:   t_r  <= prod_lo;
      DP_SUM: begin
        n_r <= n_r + t_r;
        r_r <= WW'(1);
      end
      DP_OUT: begin
        res_num_r  <= n_r;
        res_den_r  <= d_r;
        res_root_r <= r_r;
      end
      default: begin
      end
    endcase
  end

  assign status.op       = op_r;
  assign status.r_ge4    = r_r >= WW'(4);
  assign status.jj_gt_r  = jj_r > {1'b0, r_r};
  assign status.rem_zero = rem == '0;
  assign status.y_zero   = y_r == '0;
  assign status.div_done = div_done;

  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_res_root = res_root_r;

endmodule

`default_nettype wire

// ----- rtl/surd_ctrl.sv -----
`default_nettype none

module surd_ctrl import surd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [28:0] {
    S_IDLE  = 29'd1 << 0,
    S_DISP  = 29'd1 << 1,
    S_NEGB  = 29'd1 << 2,
    S_MULN  = 29'd1 << 3,
    S_MULD  = 29'd1 << 4,
    S_MULR  = 29'd1 << 5,
    S_RCHK  = 29'd1 << 6,
    S_JSQ   = 29'd1 << 7,
    S_JCMP  = 29'd1 << 8,
    S_RTEST = 29'd1 << 9,
    S_NJ    = 29'd1 << 10,
    S_GINIT = 29'd1 << 11,
    S_GCHK  = 29'd1 << 12,
    S_GSTEP = 29'd1 << 13,
    S_MDIV  = 29'd1 << 14,
    S_NUPD  = 29'd1 << 15,
    S_DDIV  = 29'd1 << 16,
    S_DUPD  = 29'd1 << 17,
    S_RET   = 29'd1 << 18,
    S_ADIV1 = 29'd1 << 19,
    S_AQ1   = 29'd1 << 20,
    S_ADIV2 = 29'd1 << 21,
    S_AQ2   = 29'd1 << 22,
    S_AML   = 29'd1 << 23,
    S_AT1   = 29'd1 << 24,
    S_AT2   = 29'd1 << 25,
    S_ASUM  = 29'd1 << 26,
    S_WAIT  = 29'd1 << 27,
    S_DONE  = 29'd1 << 28
  } state_t;

  typedef enum logic [1:0] {
    CTX_B,
    CTX_RES,
    CTX_ADD
  } ctx_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  ctx_t   ctx_r, ctx_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    ctx_nxt       = ctx_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (status.op)
          OP_ADD: begin
            ctx_nxt   = CTX_ADD;
            state_nxt = S_GINIT;
          end
          OP_SUB:  state_nxt = S_NEGB;
          default: state_nxt = S_MULN;
        endcase
      end
      S_NEGB: begin
        cmd       = DP_NEG_B;
        ctx_nxt   = CTX_B;
        state_nxt = S_RCHK;
      end
      S_MULN: begin
        cmd       = DP_MUL_N;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd       = DP_MUL_D;
        state_nxt = S_MULR;
      end
      S_MULR: begin
        cmd     = DP_MUL_R;
        ctx_nxt = CTX_RES;
        if (status.op == OP_MUL_RAW) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        cmd       = DP_JINIT;
        state_nxt = status.r_ge4 ? S_JSQ : S_GINIT;
      end
      S_JSQ: begin
        cmd       = DP_JSQ;
        state_nxt = S_JCMP;
      end
      S_JCMP: begin
        if (status.jj_gt_r) begin
          state_nxt = S_GINIT;
        end else begin
          cmd       = DP_DIV_R;
          ret_nxt   = S_RTEST;
          state_nxt = S_WAIT;
        end
      end
      S_RTEST: begin
        if (status.rem_zero) begin
          cmd       = DP_R_UPD;
          state_nxt = S_NJ;
        end else begin
          cmd       = DP_JINC;
          state_nxt = S_JSQ;
        end
      end
      S_NJ: begin
        cmd       = DP_MUL_NJ;
        state_nxt = S_JCMP;
      end
      S_GINIT: begin
        cmd       = (ctx_r == CTX_ADD) ? DP_GCD_A : DP_GCD_N;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (status.y_zero) begin
          state_nxt = (ctx_r == CTX_ADD) ? S_ADIV1 : S_MDIV;
        end else begin
          cmd       = DP_DIV_XY;
          ret_nxt   = S_GSTEP;
          state_nxt = S_WAIT;
        end
      end
      S_GSTEP: begin
        cmd       = DP_GCD_STEP;
        state_nxt = S_GCHK;
      end
      S_MDIV: begin
        cmd       = DP_DIV_M;
        ret_nxt   = S_NUPD;
        state_nxt = S_WAIT;
      end
      S_NUPD: begin
        cmd       = DP_N_UPD;
        state_nxt = S_DDIV;
      end
      S_DDIV: begin
        cmd       = DP_DIV_D;
        ret_nxt   = S_DUPD;
        state_nxt = S_WAIT;
      end
      S_DUPD: begin
        cmd       = DP_D_UPD;
        state_nxt = S_RET;
      end
      S_RET: begin
        if (ctx_r == CTX_B) begin
          cmd       = DP_B_SAVE;
          ctx_nxt   = CTX_ADD;
          state_nxt = S_GINIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ADIV1: begin
        cmd       = DP_DIV_AD;
        ret_nxt   = S_AQ1;
        state_nxt = S_WAIT;
      end
      S_AQ1: begin
        cmd       = DP_Q1;
        state_nxt = S_ADIV2;
      end
      S_ADIV2: begin
        cmd       = DP_DIV_BD;
        ret_nxt   = S_AQ2;
        state_nxt = S_WAIT;
      end
      S_AQ2: begin
        cmd       = DP_Q2;
        state_nxt = S_AML;
      end
      S_AML: begin
        cmd       = DP_MUL_L;
        state_nxt = S_AT1;
      end
      S_AT1: begin
        cmd       = DP_MUL_T1;
        state_nxt = S_AT2;
      end
      S_AT2: begin
        cmd       = DP_MUL_T2;
        state_nxt = S_ASUM;
      end
      S_ASUM: begin
        cmd       = DP_SUM;
        ctx_nxt   = CTX_RES;
        state_nxt = S_RCHK;
      end
      S_WAIT: begin
        if (status.div_done) begin
          state_nxt = ret_r;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd           = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      ctx_r       <= CTX_RES;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      ctx_r       <= ctx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DISP)
    else $error("accepted beat not dispatched");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done");

endmodule

`default_nettype wire

// ----- rtl/surd_rational_arith_unit.sv -----
`default_nettype none
// one item at a time; input stalled from acceptance until the result is registered
// raw multiply: S_DISP, S_MULN, S_MULD, S_MULR, then S_DONE raises out_valid
// other ops: add passes of the shared restoring divider,
//   one pass per gcd step, per square-factor trial j (j up to sqrt of the root) and per quotient
// next beat taken while a finished result still waits on out_stall
// synchronous active-low reset: idle, result channel empty

module surd_rational_arith_unit import surd_pkg::*; #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic signed [OPERAND_BITS-1:0]   in_a_num,
  input  logic [OPERAND_BITS-2:0]          in_a_den,
  input  logic [OPERAND_BITS-2:0]          in_a_root,
  input  logic signed [OPERAND_BITS-1:0]   in_b_num,
  input  logic [OPERAND_BITS-2:0]          in_b_den,
  input  logic [OPERAND_BITS-2:0]          in_b_root,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [3*OPERAND_BITS-2:0] out_res_num,
  output logic [2*OPERAND_BITS-3:0]        out_res_den,
  output logic [2*OPERAND_BITS-3:0]        out_res_root
);

  dp_cmd_t    cmd;
  dp_status_t status;

  surd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  surd_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_operation (in_operation),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_a_root    (in_a_root),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .in_b_root    (in_b_root),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_res_root (out_res_root)
  );

endmodule

`default_nettype wire

// ----- tb/sv/surd_rational_arith_unit_tb.sv -----
`timescale 1ns / 100ps

module surd_rational_arith_unit_tb;
  import surd_pkg::*;

  typedef struct {
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] r;
  } surd_t;

  typedef struct {
    op_t                op;
    logic signed [15:0] an;
    logic [14:0]        ad;
    logic [14:0]        ar;
    logic signed [15:0] bn;
    logic [14:0]        bd;
    logic [14:0]        br;
    bit                 typed;
    logic [46:0]        en;
    logic [29:0]        ed;
    logic [29:0]        er;
  } vec_t;

  localparam int N_RANDOM    = 1830;
  localparam int N_QUIET     = 200;
  localparam int WDOG_LIMIT  = 400000;
  localparam int LONG_HOLD   = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_operation;
  logic signed [15:0] in_a_num;
  logic [14:0] in_a_den;
  logic [14:0] in_a_root;
  logic signed [15:0] in_b_num;
  logic [14:0] in_b_den;
  logic [14:0] in_b_root;
  logic out_valid;
  logic out_stall;
  logic signed [46:0] out_res_num;
  logic [29:0] out_res_den;
  logic [29:0] out_res_root;

  surd_rational_arith_unit #(.OPERAND_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_a_root(in_a_root),
    .in_b_num(in_b_num), .in_b_den(in_b_den), .in_b_root(in_b_root),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_num(out_res_num), .out_res_den(out_res_den), .out_res_root(out_res_root)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  surd_t  expected_q[$];
  vec_t   cur_vec;
  bit     failed;
  bit     quiet;
  int     idle_cycles;

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic surd_t reduce_surd(surd_t s);
    logic [63:0] j;
    logic [63:0] m;
    logic [63:0] g;
    bit neg;
    if (s.r >= 4) begin
      for (j = 2; j * j <= s.r; j++) begin
        while (s.r % (j * j) == 0) begin
          s.r = s.r / (j * j);
          s.n = s.n * j;
        end
      end
    end
    neg = s.n[63];
    m = neg ? -s.n : s.n;
    g = gcd64(m, s.d);
    if (g > 1) begin
      m = m / g;
      s.d = s.d / g;
      s.n = neg ? -m : m;
    end
    return s;
  endfunction

  function automatic surd_t add_surd(surd_t a, surd_t b);
    surd_t s;
    logic [63:0] g;
    logic [63:0] l;
    g = gcd64(a.d, b.d);
    l = (a.d / g) * b.d;
    s.n = a.n * (l / a.d) + b.n * (l / b.d);
    s.d = l;
    s.r = 1;
    return reduce_surd(s);
  endfunction

  function automatic surd_t predict_surd(vec_t v);
    surd_t a;
    surd_t b;
    surd_t p;
    a.n = 64'(v.an);
    a.d = (v.ad == 0) ? 64'd1 : 64'(v.ad);
    a.r = 64'(v.ar);
    b.n = 64'(v.bn);
    b.d = (v.bd == 0) ? 64'd1 : 64'(v.bd);
    b.r = 64'(v.br);
    p.n = a.n * b.n;
    p.d = a.d * b.d;
    p.r = a.r * b.r;
    case (v.op)
      OP_MUL_SIMP: p = reduce_surd(p);
      OP_MUL_RAW:  ;
      OP_ADD:      p = add_surd(a, b);
      default: begin
        b.n = -b.n;
        p = add_surd(a, reduce_surd(b));
      end
    endcase
    p.n = p.n & ((64'd1 << 47) - 1);
    p.d = p.d & ((64'd1 << 30) - 1);
    p.r = p.r & ((64'd1 << 30) - 1);
    return p;
  endfunction

  function automatic vec_t mk(op_t op, int an, int ad, int ar, int bn, int bd, int br,
                              bit typed = 0, longint en = 0, longint ed = 0, longint er = 0);
    vec_t v;
    v.op = op;
    v.an = 16'(an); v.ad = 15'(ad); v.ar = 15'(ar);
    v.bn = 16'(bn); v.bd = 15'(bd); v.br = 15'(br);
    v.typed = typed;
    v.en = 47'(en); v.ed = 30'(ed); v.er = 30'(er);
    return v;
  endfunction

  function automatic vec_t random_vec();
    vec_t v;
    v = mk(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom);
    if ($urandom_range(0, 3) == 0) begin
      v.ad = 15'($urandom_range(0, 60));
      v.bd = 15'($urandom_range(0, 60));
    end
    // keep the square-factor search short on simplified multiply
    if (v.op == OP_MUL_SIMP) begin
      if ($urandom_range(0, 15) == 0) begin
        v.br = 15'($urandom_range(0, 7));
      end else begin
        v.ar = 15'($urandom_range(0, 15));
        v.br = 15'($urandom_range(0, 15));
      end
    end
    return v;
  endfunction

  // accepted input beat: queue its expectation
  always @(posedge clk) begin
    surd_t e;
    if (rst_n && in_valid && !in_stall) begin
      if (cur_vec.typed) begin
        e.n = 64'(cur_vec.en); e.d = 64'(cur_vec.ed); e.r = 64'(cur_vec.er);
      end else begin
        e = predict_surd(cur_vec);
      end
      expected_q.push_back(e);
    end
  end

  // result beat check
  always @(posedge clk) begin
    surd_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result n=%0d d=%0d r=%0d", $time, out_res_num,
                 out_res_den, out_res_root);
        failed = 1;
      end else begin
        e = expected_q.pop_front();
        if (out_res_num !== e.n[46:0]) begin
          $display("%0t: res_num expected %0d actual %0d", $time, $signed(e.n[46:0]),
                   out_res_num);
          failed = 1;
        end
        if (out_res_den !== e.d[29:0]) begin
          $display("%0t: res_den expected %0d actual %0d", $time, e.d[29:0], out_res_den);
          failed = 1;
        end
        if (out_res_root !== e.r[29:0]) begin
          $display("%0t: res_root expected %0d actual %0d", $time, e.r[29:0], out_res_root);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side stall
  initial begin
    int burst;
    int rate;
    out_stall = 1'b1;
    wait (rst_n);
    repeat (LONG_HOLD) @(negedge clk);
    forever begin
      rate = ($urandom_range(0, 2) == 0) ? 0 : 4;
      repeat (256) begin
        @(negedge clk);
        if (!quiet && rate != 0 && $urandom_range(0, rate) == 0) begin
          burst = $urandom_range(1, 9);
          out_stall <= 1'b1;
          repeat (burst) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(vec_t v);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_vec = v;
    in_operation <= v.op;
    in_a_num <= v.an; in_a_den <= v.ad; in_a_root <= v.ar;
    in_b_num <= v.bn; in_b_den <= v.bd; in_b_root <= v.br;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  vec_t directed[] = '{
    mk(OP_MUL_RAW, -32768, 32767, 32767, -32768, 32767, 32767,
       1, 64'd1073741824, 1073676289, 1073676289),
    mk(OP_MUL_RAW, 32767, 1, 1, -32768, 1, 1, 1, -1073709056, 1, 1),
    mk(OP_MUL_SIMP, 0, 5, 3, 7, 3, 2, 1, 0, 1, 6),
    mk(OP_ADD, 1, 0, 1, 1, 0, 1, 1, 2, 1, 1),
    mk(OP_MUL_SIMP, 1, 1, 8, 1, 1, 2, 1, 4, 1, 1),
    mk(OP_SUB, 3, 4, 1, 3, 4, 1, 1, 0, 1, 1),
    mk(OP_MUL_RAW, 5, 7, 0, 3, 2, 9),
    mk(OP_MUL_SIMP, 2, 3, 1, 3, 1, 3),
    mk(OP_MUL_SIMP, -6, 4, 2, 5, 9, 1),
    mk(OP_MUL_SIMP, -32768, 32767, 32767, 32767, 32767, 1),
    mk(OP_MUL_SIMP, 12, 18, 12, -9, 6, 27),
    mk(OP_MUL_SIMP, 3, 0, 0, 4, 0, 5),
    mk(OP_ADD, -32768, 32767, 32767, -32768, 32766, 16384),
    mk(OP_ADD, 32767, 1, 5, 32767, 1, 7),
    mk(OP_ADD, 5, 6, 3, -5, 6, 2),
    mk(OP_ADD, 7, 12, 9, 5, 18, 4),
    mk(OP_SUB, 1, 2, 1, 1, 3, 12),
    mk(OP_SUB, -32768, 32767, 1, 32767, 32767, 32767),
    mk(OP_SUB, 0, 0, 0, 0, 0, 0),
    mk(OP_SUB, 4, 9, 3, -8, 6, 18),
    mk(OP_MUL_RAW, 0, 0, 0, 0, 0, 0)
  };

  initial begin
    failed = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_MUL_SIMP;
    in_a_num = '0; in_a_den = '0; in_a_root = '0;
    in_b_num = '0; in_b_den = '0; in_b_root = '0;
    cur_vec = mk(OP_MUL_SIMP, 0, 0, 0, 0, 0, 0);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_beat(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_QUIET) quiet = 1;
      send_beat(random_vec());
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/surd_pkg.sv
rtl/surd_div.sv
rtl/surd_dp.sv
rtl/surd_ctrl.sv
rtl/surd_rational_arith_unit.sv
tb/sv/surd_rational_arith_unit_tb.sv
